// ----- src/prr_pkg.sv -----
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants of the polyline resampler
// Field widths, register indexes, stream layout and sequencer codes.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int unsigned CoordW  = 40;   // input coordinates, Q10 m
  localparam int unsigned DiffW   = 41;   // edge deltas, lengths, quotients
  localparam int unsigned ProdW   = 82;   // squares and scaled products
  localparam int unsigned OutW    = 32;   // rotated coordinates
  localparam int unsigned TrigW   = 16;   // Q14 cosine and sine
  localparam int unsigned SpaceW  = 17;   // sample spacing
  localparam int unsigned OffW    = 32;   // carried arc offset
  localparam int unsigned RotW    = 57;   // one rotation product
  localparam int unsigned CfgW    = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 208;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCenterX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCenterY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRotCos  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRotSin  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSpacing = 3'd4;

  localparam logic [OutW-1:0]   MinReset   = 32'h7FFF_FFFF;
  localparam logic [TrigW-1:0]  CosReset   = 16'sd16384;
  localparam logic [SpaceW-1:0] SpaceReset = 17'd1024;

  // Last iteration index of the serial loops: one quotient, product or root bit each.
  localparam logic [5:0] LastStep = 6'd40;

  // Last step index of the rotation sequence.
  localparam logic [2:0] RotLast = 3'd5;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_SQRT = 9'b000000100,
    S_LEN  = 9'b000001000,
    S_RND  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_ROT  = 9'b001000000,
    S_TAKE = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    JobSqX  = 3'd0,
    JobSqY  = 3'd1,
    JobCnt  = 3'd2,
    JobScX  = 3'd3,
    JobScY  = 3'd4
  } job_e;

endpackage

// ----- src/polyline_resample_rotate.sv -----
// ----------------------------------------------------------------------------
// polyline_resample_rotate: arc-length resampler with rotation
// Resamples polyline points at a fixed arc-length spacing, moves each sample
// into a rotated local frame and emits consecutive samples as vectors.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tdata                          | tuser / tlast
//  ----------+-----------+--------------------------------+--------------------
//  s_axis    | in        | point x/y, attribute, boundary,| tuser: polyline and
//            |           | polyline id                    | segment start flags
//  m_axis    | out       | start, end, codes, id, minima  | tuser: dropped,
//            |           |                                | tlast: last of point
//  cfg       | in        | write enable, index, data      | none
//
// A start point runs through the rotation sequence when it is sampled and
// goes straight to the finish state otherwise. Any other point first gets its
// edge length (two serial squares, a root and, when the edge holds a sample, a
// division for the sample count), then for each sample two serial products
// and two divisions for the interpolation and the steps on the rotation
// multiplier. Products and divisions share one shift-add/subtract unit. Input
// is not ready while a point is in work; a stalled output beat holds the
// sequencer only when the next vector is due.
// Reset clears the carried state, sets the running minima to MinReset and loads the register defaults.
//
module polyline_resample_rotate import prr_pkg::*; #(
  parameter int unsigned MAX_SAMPLES_PER_EDGE = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_x, point_y, attribute, boundary, polyline_id
  input  logic [InDataW-1:0]   s_axis_tdata,
  // starts_polyline, starts_segment
  input  logic [InUserW-1:0]   s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // start_x, start_y, end_x, end_y, attr_code, bound_code, vector_polyline,
  // min_x, min_y
  output logic [OutDataW-1:0]  m_axis_tdata,
  output logic                 m_axis_tlast,
  // dropped
  output logic                 m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  // Sample counter width: holds every count from zero up to the edge limit.
  localparam int unsigned KW = $clog2(MAX_SAMPLES_PER_EDGE + 1);

  // Round half up by 2^14 and saturate to the 32-bit output range.
  function automatic logic [OutW-1:0] rnd_sat(input logic signed [RotW:0] v);
    logic signed [RotW+1:0] w;
    logic signed [RotW-13:0] q;
    w = $signed({v[RotW], v}) + $signed((RotW+2)'(8192));
    q = w[RotW+1:14];
    if (q > $signed((RotW-12)'(64'h7FFF_FFFF))) begin
      rnd_sat = 32'h7FFF_FFFF;
    end else if (q < -$signed((RotW-12)'(64'h8000_0000))) begin
      rnd_sat = 32'h8000_0000;
    end else begin
      rnd_sat = q[OutW-1:0];
    end
  endfunction

  // Configuration.
  logic [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [TrigW-1:0]  cos_q, cos_d, sin_q, sin_d;
  logic [SpaceW-1:0] space_q, space_d, step;

  // Carried state.
  state_e            state_q, state_d;
  logic [CoordW-1:0] prev_px_q, prev_px_d, prev_py_q, prev_py_d;
  logic [OffW-1:0]   offset_q, offset_d;
  logic [OutW-1:0]   prev_rx_q, prev_rx_d, prev_ry_q, prev_ry_d;
  logic              have_q, have_d;
  logic [OutW-1:0]   min_x_q, min_x_d, min_y_q, min_y_d;
  logic              out_valid_q, out_valid_d;

  // Item and loop registers.
  job_e              job_q, job_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [DiffW-1:0]  mcand_q, mcand_d, divisor_q, divisor_d;
  logic [ProdW-1:0]  sq_q, sq_d;
  logic [DiffW-1:0]  root_q, root_d;
  logic [DiffW+2:0]  srem_q, srem_d;
  logic [DiffW-1:0]  len_q, len_d;
  logic [CoordW-1:0] in_px_q, in_px_d, in_py_q, in_py_d;
  logic [3:0]        attr_q, attr_d;
  logic [1:0]        bound_q, bound_d;
  logic [9:0]        id_q, id_d;
  logic              negx_q, negx_d, negy_q, negy_d;
  logic [DiffW-1:0]  magx_q, magx_d, magy_q, magy_d;
  logic [DiffW-1:0]  ok_q, ok_d;
  logic [KW-1:0]     k_q, k_d, n_q, n_d;
  logic              drop_q, drop_d, start_br_q, start_br_d;
  logic [CoordW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [DiffW-1:0]  ra_q, ra_d, rb_q, rb_d;
  logic [RotW-1:0]   mprod_q, mprod_d, macc_q, macc_d;
  logic [OutW-1:0]   rx_q, rx_d, ry_q, ry_d;
  logic [2:0]        rcnt_q, rcnt_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d, out_drop_q, out_drop_d;

  // Shared shift-add/subtract unit: one multiply or divide bit per cycle.
  logic [DiffW:0]    mul_sum, div_t, div_r;
  logic              div_ge;
  logic [ProdW-1:0]  mul_next, div_next;
  // Root unit: two radicand bits per cycle.
  logic [DiffW+2:0]  srem_sh, trial;
  logic              sq_ge;
  // Rotation multiplier.
  logic [DiffW-1:0]  rot_a;
  logic [TrigW-1:0]  rot_b;
  logic signed [RotW-1:0] rot_prod;

  // Input unpacking.
  logic [CoordW-1:0] in_px, in_py;
  logic              in_poly, in_seg, in_acc, out_acc;
  logic [DiffW-1:0]  dx, dy, qv, qoff;
  logic [OutW-1:0]   nmin_x, nmin_y;

  assign in_px   = s_axis_tdata[39:0];
  assign in_py   = s_axis_tdata[79:40];
  assign in_poly = s_axis_tuser[0];
  assign in_seg  = s_axis_tuser[1];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = out_valid_q && m_axis_tready;
  assign step    = (space_q == '0) ? SpaceW'(1) : space_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;

  assign mul_sum  = {1'b0, prod_q[ProdW-1:DiffW]} +
                    (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign mul_next = {mul_sum, prod_q[DiffW-1:1]};
  assign div_t    = {prod_q[ProdW-1:DiffW], prod_q[DiffW-1]};
  assign div_ge   = (div_t >= {1'b0, divisor_q});
  assign div_r    = div_t - {1'b0, divisor_q};
  assign div_next = {(div_ge ? div_r[DiffW-1:0] : div_t[DiffW-1:0]),
                     prod_q[DiffW-2:0], div_ge};

  assign srem_sh = {srem_q[DiffW:0], sq_q[ProdW-1:ProdW-2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign sq_ge   = (srem_sh >= trial);

  assign rot_a    = (rcnt_q == 3'd1 || rcnt_q == 3'd3) ? ra_q : rb_q;
  assign rot_b    = (rcnt_q == 3'd1 || rcnt_q == 3'd4) ? cos_q : sin_q;
  assign rot_prod = $signed(rot_a) * $signed(rot_b);

  assign dx = {in_px[CoordW-1], in_px} - {prev_px_q[CoordW-1], prev_px_q};
  assign dy = {in_py[CoordW-1], in_py} - {prev_py_q[CoordW-1], prev_py_q};

  // Interpolation quotient; a zero-length edge places the sample on its start.
  assign qv   = (len_q == '0) ? '0 : div_next[DiffW-1:0];
  assign qoff = ((job_q == JobScX) ? negx_q : negy_q) ? (DiffW'(0) - qv) : qv;

  assign nmin_x = ($signed(prev_rx_q) < $signed(min_x_q)) ? prev_rx_q : min_x_q;
  assign nmin_y = ($signed(prev_ry_q) < $signed(min_y_q)) ? prev_ry_q : min_y_q;

  always_comb begin
    cx_d = cx_q; cy_d = cy_q; cos_d = cos_q; sin_d = sin_q; space_d = space_q;
    state_d = state_q;
    prev_px_d = prev_px_q; prev_py_d = prev_py_q;
    offset_d = offset_q;
    prev_rx_d = prev_rx_q; prev_ry_d = prev_ry_q;
    have_d = have_q;
    min_x_d = min_x_q; min_y_d = min_y_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;
    job_d = job_q; cnt_d = cnt_q; prod_d = prod_q; mcand_d = mcand_q;
    divisor_d = divisor_q; sq_d = sq_q; root_d = root_q; srem_d = srem_q;
    len_d = len_q; in_px_d = in_px_q; in_py_d = in_py_q;
    attr_d = attr_q; bound_d = bound_q; id_d = id_q;
    negx_d = negx_q; negy_d = negy_q; magx_d = magx_q; magy_d = magy_q;
    ok_d = ok_q; k_d = k_q; n_d = n_q; drop_d = drop_q; start_br_d = start_br_q;
    sx_d = sx_q; sy_d = sy_q; ra_d = ra_q; rb_d = rb_q;
    mprod_d = mprod_q; macc_d = macc_q; rx_d = rx_q; ry_d = ry_q; rcnt_d = rcnt_q;
    out_data_d = out_data_q; out_last_d = out_last_q; out_drop_d = out_drop_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCenterX: cx_d    = cfg_data_i;
        CfgCenterY: cy_d    = cfg_data_i;
        CfgRotCos:  cos_d   = cfg_data_i[TrigW-1:0];
        CfgRotSin:  sin_d   = cfg_data_i[TrigW-1:0];
        CfgSpacing: space_d = cfg_data_i[SpaceW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_px_d = in_px;
          in_py_d = in_py;
          attr_d  = s_axis_tdata[83:80];
          bound_d = s_axis_tdata[85:84];
          id_d    = s_axis_tdata[95:86];
          if (in_poly) begin
            offset_d = '0;
            min_x_d  = MinReset;
            min_y_d  = MinReset;
          end
          if (in_poly || in_seg) begin
            // Start point: break the chain; sample the point if a polyline starts or the offset is zero.
            have_d     = 1'b0;
            start_br_d = 1'b1;
            if (in_poly || offset_q == '0) begin
              sx_d    = in_px;
              sy_d    = in_py;
              rcnt_d  = '0;
              state_d = S_ROT;
            end else begin
              state_d = S_FIN;
            end
          end else begin
            start_br_d = 1'b0;
            negx_d  = dx[DiffW-1];
            negy_d  = dy[DiffW-1];
            magx_d  = dx[DiffW-1] ? (DiffW'(0) - dx) : dx;
            magy_d  = dy[DiffW-1] ? (DiffW'(0) - dy) : dy;
            prod_d  = {DiffW'(0), magx_d};
            mcand_d = magx_d;
            ok_d    = DiffW'(offset_q);
            job_d   = JobSqX;
            cnt_d   = LastStep;
            state_d = S_MUL;
          end
        end
      end

      S_MUL: begin
        prod_d = mul_next;
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          case (job_q)
            JobSqX: begin
              sq_d    = mul_next;
              prod_d  = {DiffW'(0), magy_q};
              mcand_d = magy_q;
              job_d   = JobSqY;
              cnt_d   = LastStep;
            end
            JobSqY: begin
              sq_d    = sq_q + mul_next;
              root_d  = '0;
              srem_d  = '0;
              cnt_d   = LastStep;
              state_d = S_SQRT;
            end
            default: state_d = S_RND;
          endcase
        end
      end

      S_SQRT: begin
        sq_d   = {sq_q[ProdW-3:0], 2'b00};
        srem_d = sq_ge ? (srem_sh - trial) : srem_sh;
        root_d = {root_q[DiffW-2:0], sq_ge};
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          len_d   = {root_q[DiffW-2:0], sq_ge};
          state_d = S_LEN;
        end
      end

      S_LEN: begin
        if (ok_q > len_q) begin
          // No sample on this edge; carry the rest of the offset.
          offset_d = OffW'(ok_q - len_q);
          state_d  = S_FIN;
        end else begin
          prod_d    = {DiffW'(0), len_q - ok_q};
          divisor_d = DiffW'(step);
          job_d     = JobCnt;
          cnt_d     = LastStep;
          state_d   = S_DIV;
        end
      end

      S_RND: begin
        prod_d    = prod_q + ProdW'(len_q[DiffW-1:1]);
        divisor_d = len_q;
        cnt_d     = LastStep;
        state_d   = S_DIV;
      end

      S_DIV: begin
        prod_d = div_next;
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          case (job_q)
            JobCnt: begin
              drop_d   = (div_next[DiffW-1:0] >= DiffW'(MAX_SAMPLES_PER_EDGE));
              n_d      = drop_d ? KW'(MAX_SAMPLES_PER_EDGE)
                                : (div_next[KW-1:0] + KW'(1));
              offset_d = OffW'(step) - OffW'(div_next[ProdW-1:DiffW]);
              k_d      = '0;
              prod_d   = {DiffW'(0), ok_q};
              mcand_d  = magx_q;
              job_d    = JobScX;
              cnt_d    = LastStep;
              state_d  = S_MUL;
            end
            JobScX: begin
              sx_d    = prev_px_q + qoff[CoordW-1:0];
              prod_d  = {DiffW'(0), ok_q};
              mcand_d = magy_q;
              job_d   = JobScY;
              cnt_d   = LastStep;
              state_d = S_MUL;
            end
            default: begin
              sy_d    = prev_py_q + qoff[CoordW-1:0];
              rcnt_d  = '0;
              state_d = S_ROT;
            end
          endcase
        end
      end

      S_ROT: begin
        rcnt_d = rcnt_q + 3'd1;
        case (rcnt_q)
          3'd0: begin
            ra_d = {sx_q[CoordW-1], sx_q} - {cx_q[CoordW-1], cx_q};
            rb_d = {sy_q[CoordW-1], sy_q} - {cy_q[CoordW-1], cy_q};
          end
          3'd1: mprod_d = rot_prod;
          3'd2: begin
            macc_d  = mprod_q;
            mprod_d = rot_prod;
          end
          3'd3: begin
            rx_d    = rnd_sat($signed({macc_q[RotW-1], macc_q}) -
                              $signed({mprod_q[RotW-1], mprod_q}));
            mprod_d = rot_prod;
          end
          3'd4: begin
            macc_d  = mprod_q;
            mprod_d = rot_prod;
          end
          default: begin
            ry_d    = rnd_sat($signed({macc_q[RotW-1], macc_q}) +
                              $signed({mprod_q[RotW-1], mprod_q}));
            state_d = S_TAKE;
          end
        endcase
      end

      S_TAKE: begin
        // A vector leaves only when the output register is free.
        if (!(have_q && out_valid_q && !m_axis_tready)) begin
          if (have_q) begin
            min_x_d     = nmin_x;
            min_y_d     = nmin_y;
            out_valid_d = 1'b1;
            out_data_d  = {nmin_y, nmin_x, id_q, bound_q, attr_q,
                           ry_q, rx_q, prev_ry_q, prev_rx_q};
            out_last_d  = (k_q == n_q - KW'(1));
            out_drop_d  = drop_q;
          end
          prev_rx_d = rx_q;
          prev_ry_d = ry_q;
          have_d    = 1'b1;
          if (start_br_q) begin
            offset_d = OffW'(step);
            state_d  = S_FIN;
          end else if (k_q != n_q - KW'(1)) begin
            k_d     = k_q + KW'(1);
            ok_d    = ok_q + DiffW'(step);
            prod_d  = {DiffW'(0), ok_d};
            mcand_d = magx_q;
            job_d   = JobScX;
            cnt_d   = LastStep;
            state_d = S_MUL;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        prev_px_d = in_px_q;
        prev_py_d = in_py_q;
        state_d   = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      cos_q       <= CosReset;
      sin_q       <= '0;
      space_q     <= SpaceReset;
      state_q     <= S_IDLE;
      prev_px_q   <= '0;
      prev_py_q   <= '0;
      offset_q    <= '0;
      prev_rx_q   <= '0;
      prev_ry_q   <= '0;
      have_q      <= 1'b0;
      min_x_q     <= MinReset;
      min_y_q     <= MinReset;
      out_valid_q <= 1'b0;
    end else begin
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      cos_q       <= cos_d;
      sin_q       <= sin_d;
      space_q     <= space_d;
      state_q     <= state_d;
      prev_px_q   <= prev_px_d;
      prev_py_q   <= prev_py_d;
      offset_q    <= offset_d;
      prev_rx_q   <= prev_rx_d;
      prev_ry_q   <= prev_ry_d;
      have_q      <= have_d;
      min_x_q     <= min_x_d;
      min_y_q     <= min_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    cnt_q      <= cnt_d;
    prod_q     <= prod_d;
    mcand_q    <= mcand_d;
    divisor_q  <= divisor_d;
    sq_q       <= sq_d;
    root_q     <= root_d;
    srem_q     <= srem_d;
    len_q      <= len_d;
    in_px_q    <= in_px_d;
    in_py_q    <= in_py_d;
    attr_q     <= attr_d;
    bound_q    <= bound_d;
    id_q       <= id_d;
    negx_q     <= negx_d;
    negy_q     <= negy_d;
    magx_q     <= magx_d;
    magy_q     <= magy_d;
    ok_q       <= ok_d;
    k_q        <= k_d;
    n_q        <= n_d;
    drop_q     <= drop_d;
    start_br_q <= start_br_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    mprod_q    <= mprod_d;
    macc_q     <= macc_d;
    rx_q       <= rx_d;
    ry_q       <= ry_d;
    rcnt_q     <= rcnt_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

endmodule

// ----- src/prr_checker.sv -----
// ----------------------------------------------------------------------------
// prr_checker: port-level checks of the polyline resampler
// Watches the stream ports and flags protocol and ordering slips.
// ----------------------------------------------------------------------------
module prr_checker import prr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast,
  input logic                m_axis_tuser
);

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // Every accepted point occupies the sequencer: ready is low in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // While a vector that is not the last of its point waits, no point is taken.
  a_busy_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready before all vectors of a point left");

  // The running minima never exceed the start of the vector they travel with.
  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[175:144]) <= $signed(m_axis_tdata[31:0])) &&
      ($signed(m_axis_tdata[207:176]) <= $signed(m_axis_tdata[63:32])))
    else $error("running minimum above vector start");

endmodule

bind polyline_resample_rotate prr_checker u_prr_checker (.*);

// ----- bench/tb_polyline_resample_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_resample_rotate: self-checking bench for the polyline resampler
// Drives points with random bursts and gaps while the output side stalls on
// its own pattern. A behavioral predictor computes the expected vectors. Each
// output beat is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_polyline_resample_rotate;
  import prr_pkg::*;

  localparam int MaxPerEdge = 64;
  localparam longint RunLimit = 15000000;
  localparam int SettleCycles = 450;
  localparam longint CoordMax = 64'sd549755813887;
  localparam longint CoordMin = -64'sd549755813888;

  // One output vector as the block presents it.
  typedef struct {
    logic signed [OutW-1:0] sx, sy, ex, ey;
    logic [3:0] attr;
    logic [1:0] bnd;
    logic [9:0] pid;
    logic signed [OutW-1:0] mnx, mny;
    logic last, drop;
  } vec_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;   // point_x, point_y, attribute, boundary, polyline_id
  logic [InUserW-1:0] s_axis_tuser;   // starts_polyline, starts_segment
  logic m_axis_tvalid, m_axis_tready;
  // start_x, start_y, end_x, end_y, attr_code, bound_code, vector_polyline, min_x, min_y
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;                 // dropped
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  polyline_resample_rotate DUT (.*);

  // Predictor copy of the registers and of the carried resampling state.
  longint ctr_x, ctr_y, cos_q14, sin_q14;
  longint unsigned spacing;
  longint last_px, last_py;
  longint unsigned arc_off;
  longint smp_rx, smp_ry;
  bit have_smp;
  longint min_rx, min_ry;

  vec_t vec_queue[$];
  int burst_left, mismatches, n_points, n_vectors, n_dropped;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver switches between always ready, mostly ready, coin flip and
  // a sparse comb pattern, each held for a random stretch of cycles.
  int rdy_mode, rdy_len, rdy_ph;
  always @(posedge clk_i) begin
    if (rdy_len == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_len = $urandom_range(20, 300);
    end
    rdy_len--;
    rdy_ph++;
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (rdy_ph % 8 < 2);
    endcase
  end

  // Every accepted output beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    vec_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sx = m_axis_tdata[31:0];
      got.sy = m_axis_tdata[63:32];
      got.ex = m_axis_tdata[95:64];
      got.ey = m_axis_tdata[127:96];
      got.attr = m_axis_tdata[131:128];
      got.bnd = m_axis_tdata[133:132];
      got.pid = m_axis_tdata[143:134];
      got.mnx = m_axis_tdata[175:144];
      got.mny = m_axis_tdata[207:176];
      got.last = m_axis_tlast;
      got.drop = m_axis_tuser;
      if (vec_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected vector %p", got);
      end else begin
        want = vec_queue.pop_front();
        if (got.sx !== want.sx || got.sy !== want.sy || got.ex !== want.ex ||
            got.ey !== want.ey || got.attr !== want.attr || got.bnd !== want.bnd ||
            got.pid !== want.pid || got.mnx !== want.mnx || got.mny !== want.mny ||
            got.last !== want.last || got.drop !== want.drop) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: vector mismatch at cycle %0d", cycles);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
        n_vectors++;
        if (got.drop) n_dropped++;
      end
    end
  end

  // Floor of the Euclidean edge length, by digit-pair square root.
  function automatic longint unsigned edge_length(longint dx, longint dy);
    bit [83:0] sq, r, rem;
    bit [83:0] ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sq = ax * ax + ay * ay;
    r = 0;
    rem = 0;
    for (int i = 41; i >= 0; i--) begin
      rem = (rem << 2) | ((sq >> (2 * i)) & 84'd3);
      if (rem >= ((r << 2) | 1)) begin
        rem = rem - ((r << 2) | 1);
        r = (r << 1) | 1;
      end else begin
        r = r << 1;
      end
    end
    return r[63:0];
  endfunction

  // d * num / den rounded half away from zero.
  function automatic longint interp(longint d, longint unsigned num, longint unsigned den);
    bit [127:0] w, mag;
    if (den == 0) return 0;
    mag = d < 0 ? -d : d;
    w = (mag * num + den / 2) / den;
    return d < 0 ? -longint'(w[63:0]) : longint'(w[63:0]);
  endfunction

  // Q14 product back to Q10 metres, rounded half up, clipped to 32 bits.
  function automatic longint q14_round(longint v);
    longint q;
    q = (v + 8192) >>> 14;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Rotates one sample and, when a chain is open, forms the vector to it.
  task automatic rotate_sample(input longint sx, input longint sy, input logic [3:0] attr,
                               input logic [1:0] bnd, input logic [9:0] pid,
                               input bit drop, inout vec_t vecs[$]);
    longint a, b, rx, ry;
    vec_t v;
    a = sx - ctr_x;
    b = sy - ctr_y;
    rx = q14_round(a * cos_q14 - b * sin_q14);
    ry = q14_round(a * sin_q14 + b * cos_q14);
    if (have_smp && vecs.size() < MaxPerEdge) begin
      if (smp_rx < min_rx) min_rx = smp_rx;
      if (smp_ry < min_ry) min_ry = smp_ry;
      v.sx = OutW'(smp_rx); v.sy = OutW'(smp_ry); v.ex = OutW'(rx); v.ey = OutW'(ry);
      v.attr = attr; v.bnd = bnd; v.pid = pid;
      v.mnx = OutW'(min_rx); v.mny = OutW'(min_ry);
      v.last = 1'b0; v.drop = drop;
      vecs = {vecs, v};
    end
    smp_rx = rx;
    smp_ry = ry;
    have_smp = 1'b1;
  endtask

  // Expected vectors for one accepted point.
  task automatic resample_point(input longint px, input longint py, input bit poly,
                                input bit seg, input logic [3:0] attr,
                                input logic [1:0] bnd, input logic [9:0] pid);
    vec_t vecs[$];
    longint dx, dy;
    longint unsigned len, o, n, stp;
    bit drop;
    stp = spacing == 0 ? 1 : spacing;
    if (poly) begin
      arc_off = 0;
      min_rx = 64'sd2147483647;
      min_ry = 64'sd2147483647;
    end
    if (poly || seg) begin
      have_smp = 1'b0;
      if (arc_off == 0) begin
        rotate_sample(px, py, attr, bnd, pid, 1'b0, vecs);
        arc_off = stp;
      end
    end else begin
      dx = px - last_px;
      dy = py - last_py;
      len = edge_length(dx, dy);
      o = arc_off;
      if (o > len) begin
        arc_off = (o - len) & 64'hFFFF_FFFF;
      end else begin
        n = (len - o) / stp + 1;
        arc_off = (stp - (len - o) % stp) & 64'hFFFF_FFFF;
        drop = n > MaxPerEdge;
        if (drop) n = MaxPerEdge;
        for (longint unsigned k = 0; k < n; k++)
          rotate_sample(last_px + interp(dx, o + k * stp, len),
                        last_py + interp(dy, o + k * stp, len),
                        attr, bnd, pid, drop, vecs);
      end
    end
    last_px = px;
    last_py = py;
    if (vecs.size() > 0) vecs[vecs.size() - 1].last = 1'b1;
    vec_queue = {vec_queue, vecs};
  endtask

  // Sends one point; bursts of random length are separated by random gaps.
  task automatic send_point(input longint px, input longint py, input bit poly,
                            input bit seg, input logic [3:0] attr = 4'd0,
                            input logic [1:0] bnd = 2'd0, input logic [9:0] pid = 10'd0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pid, bnd, attr, py[39:0], px[39:0]};
    s_axis_tuser <= {seg, poly};
    do @(posedge clk_i); while (!s_axis_tready);
    resample_point(px, py, poly, seg, attr, bnd, pid);
    n_points++;
  endtask

  // Holds the input until every expected vector is out and the block is idle.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (vec_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all five registers, one per cycle, while the block is idle.
  task automatic load_registers(input longint cx, input longint cy, input longint c,
                                input longint s, input longint unsigned sp);
    logic [CfgW-1:0] vals[5];
    logic [CfgIdxW-1:0] idx[5];
    vals = '{cx[39:0], cy[39:0], c[39:0], s[39:0], sp[39:0]};
    idx = '{CfgCenterX, CfgCenterY, CfgRotCos, CfgRotSin, CfgSpacing};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    ctr_x = cx; ctr_y = cy; cos_q14 = c; sin_q14 = s; spacing = sp & 64'h1FFFF;
  endtask

  function automatic longint rand_coord();
    logic [39:0] t;
    t = {8'($urandom), $urandom};
    return longint'($signed(t));
  endfunction

  function automatic longint rand_step(longint unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  // Edges from reset, polyline and segment starts, both flags, short edges
  // with no sample, long edges that overflow the per-edge limit and
  // coordinates that saturate after rotation.
  task automatic test_directed();
    send_point(3000, 1000, 0, 0, 4'd5, 2'd1, 10'd7);
    send_point(0, 0, 1, 0, 4'd15, 2'd3, 10'd1023);
    send_point(4096, 0, 0, 0, 4'd15, 2'd3, 10'd1023);
    send_point(4096, -5000, 0, 0, 4'd2, 2'd2, 10'd1);
    send_point(4096, -5000, 0, 1, 4'd2, 2'd2, 10'd1);
    send_point(0, -5000, 0, 0, 4'd3, 2'd1, 10'd1);
    send_point(0, -5000, 0, 0, 4'd3, 2'd1, 10'd1);
    send_point(CoordMin, CoordMin + 200, 1, 1, 4'd0, 2'd0, 10'd0);
    send_point(CoordMin + 500, CoordMin + 200, 0, 0, 4'd0, 2'd0, 10'd0);
    send_point(CoordMin + 3000, CoordMin + 3000, 0, 0, 4'd0, 2'd0, 10'd0);
    send_point(CoordMax, CoordMax, 1, 0, 4'd9, 2'd1, 10'd512);
    send_point(CoordMax - 1000000, CoordMax - 70000, 0, 0, 4'd9, 2'd1, 10'd512);
    send_point(CoordMin, CoordMax, 1, 0, 4'd6, 2'd2, 10'd3);
    send_point(CoordMax, CoordMin, 0, 0, 4'd6, 2'd2, 10'd3);
    drain_block();
  endtask

  // Register extremes: far centers, negative and quarter-turn rotations,
  // the finest and a coarse spacing.
  task automatic test_register_extremes();
    load_registers(CoordMin, CoordMax, -16384, 16384, 1);
    send_point(100, -100, 1, 0, 4'd1, 2'd0, 10'd20);
    send_point(120, -90, 0, 0, 4'd1, 2'd0, 10'd20);
    send_point(90, -95, 0, 0, 4'd1, 2'd0, 10'd20);
    drain_block();
    load_registers(CoordMax, CoordMin, 0, -16384, 102400);
    send_point(-300000, 5, 1, 0, 4'd12, 2'd3, 10'd21);
    send_point(-10000, 300000, 0, 0, 4'd12, 2'd3, 10'd21);
    send_point(-10000, 300000, 0, 1, 4'd12, 2'd3, 10'd21);
    send_point(200000, 250000, 0, 0, 4'd12, 2'd3, 10'd21);
    drain_block();
  endtask

  // Random polylines: random origin, short random edges with occasional
  // segment breaks and a few wild points; registers change between phases.
  task automatic test_random_polylines();
    longint px, py, bx, by, sp;
    logic [9:0] pid;
    for (int ph = 0; ph < 5; ph++) begin
      sp = $urandom_range(0, 3) == 0 ? $urandom_range(1, 102400) : $urandom_range(64, 4096);
      load_registers(rand_coord() >>> 2, rand_coord() >>> 2,
                     longint'($urandom_range(0, 32768)) - 16384,
                     longint'($urandom_range(0, 32768)) - 16384, sp);
      for (int p = 0; p < 6; p++) begin
        bx = rand_coord() >>> 1;
        by = rand_coord() >>> 1;
        px = bx;
        py = by;
        pid = 10'($urandom);
        send_point(px, py, 1, 1'($urandom_range(0, 1)), 4'($urandom), 2'($urandom), pid);
        repeat ($urandom_range(2, 7)) begin
          if ($urandom_range(0, 24) == 0) begin
            send_point(rand_coord(), rand_coord(), 0, 0, 4'($urandom), 2'($urandom), pid);
          end else begin
            px += rand_step(4 * sp);
            py += rand_step(4 * sp);
            send_point(px, py, 0, $urandom_range(0, 7) == 0, 4'($urandom), 2'($urandom),
                       pid);
          end
        end
      end
      drain_block();
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgCenterX;
    cfg_data_i <= '0;
    rdy_len = 0;
    rdy_ph = 0;
    cycles = 0;
    burst_left = 0;
    mismatches = 0;
    n_points = 0;
    n_vectors = 0;
    n_dropped = 0;
    ctr_x = 0; ctr_y = 0; cos_q14 = 16384; sin_q14 = 0; spacing = 1024;
    last_px = 0; last_py = 0; arc_off = 0;
    smp_rx = 0; smp_ry = 0; have_smp = 1'b0;
    min_rx = 64'sd2147483647; min_ry = 64'sd2147483647;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_random_polylines();

    $display("Covered %0d points and %0d vectors, %0d of them flagged as dropped.",
             n_points, n_vectors, n_dropped);
    if (mismatches == 0 && vec_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d vectors never seen", mismatches, vec_queue.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/prr_pkg.sv
src/polyline_resample_rotate.sv
src/prr_checker.sv
bench/tb_polyline_resample_rotate.sv
